// ===== hdl/crs_pkg.sv =====
// shared constants for the catmull-rom spline evaluator
// no dependencies
package crs_pkg;
	localparam int COORD_WIDTH_DEF  = 24;
	localparam int T_FRAC_BITS_DEF  = 16;
	localparam int MAX_SEGMENTS_DEF = 63;
	localparam int SEG_CNT_W        = 6;
	localparam logic [SEG_CNT_W-1:0] SEG_CNT_RESET = 6'd16;
	// coefficient growth over a coordinate: c spans twelve times a point
	localparam int COEF_GROWTH      = 4;
endpackage

// ===== hdl/catmull_rom_spline_evaluator_core.sv =====
// uniform catmull-rom spline evaluator, top level
// depends on crs_pkg, crs_front, crs_queue, crs_back
//
// streams 3d control points in signed q15.8 and emits the points of each
// uniform catmull-rom segment between the middle two points of the last four
// taken. the first three points of a curve (or after new_curve) only fill
// the history. each later point queues one segment job; the back end turns
// a job into segment_count+1 curve points (clamped to 1..MAX_SEGMENTS), the
// final one flagged with last_of_segment. per job the back end loads the
// job, runs its bit-serial reciprocal divider, then issues one output
// point per cycle while the output does not stall, and waits for its
// evaluation pipeline to drain before starting the next job.
// the two-entry job queue lets the front keep taking points meanwhile.
// segment_count is written over the cfg channel and must only change while
// the block is idle.
module catmull_rom_spline_evaluator_core import crs_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF,
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration request
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [SEG_CNT_W-1:0]          cfg_data,
	// control point request
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          new_curve,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic signed [COORD_WIDTH-1:0] z_coord,
	// curve point request
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          last_of_segment
);
	localparam int JOB_W = 12*(COORD_WIDTH+COEF_GROWTH);

	logic [SEG_CNT_W-1:0] seg_count_q;
	logic                 fq_valid, fq_ready, qb_valid, qb_ready;
	logic [JOB_W-1:0]     fq_data, qb_data;

	// config register always takes writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEG_CNT_RESET;
		end else if (cfg_valid) begin
			seg_count_q <= cfg_data;
		end
	end

	// history and coefficient builder
	crs_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.new_curve (new_curve),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.job_valid (fq_valid),
		.job_ready (fq_ready),
		.job_data  (fq_data)
	);

	// decouples point intake from segment evaluation
	crs_queue #(
		.DATA_W(JOB_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_data)
	);

	// per-segment evaluation
	crs_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.T_FRAC_BITS (T_FRAC_BITS),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (qb_valid),
		.job_ready       (qb_ready),
		.job_data        (qb_data),
		.seg_count       (seg_count_q),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_z           (out_z),
		.last_of_segment (last_of_segment)
	);
endmodule

// ===== hdl/crs_front.sv =====
// front end: takes control points, keeps the history, builds segment coefficients
// depends on crs_pkg
module crs_front import crs_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          new_curve,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic signed [COORD_WIDTH-1:0] z_coord,
	output logic                          job_valid,
	input  logic                          job_ready,
	output logic [12*(COORD_WIDTH+COEF_GROWTH)-1:0] job_data
);
	localparam int W  = COORD_WIDTH;
	localparam int CW = COORD_WIDTH + COEF_GROWTH;

	logic [1:0]     held_q;
	logic [1:0]     held_eff;
	logic [3*W-1:0] hist_q [3];
	logic [3*W-1:0] np;
	logic           accept;

	assign np       = {x_coord, y_coord, z_coord};
	assign held_eff = new_curve ? 2'd0 : held_q;
	assign in_ready = job_ready;
	assign accept   = in_valid && in_ready;
	assign job_valid = accept && (held_eff == 2'd3);

	always_comb begin
		logic signed [CW-1:0] p0, p1, p2, p3;
		job_data = '0;
		for (int k = 0; k < 3; k++) begin
			p0 = CW'($signed(hist_q[0][k*W +: W]));
			p1 = CW'($signed(hist_q[1][k*W +: W]));
			p2 = CW'($signed(hist_q[2][k*W +: W]));
			p3 = CW'($signed(np[k*W +: W]));
			job_data[k*4*CW + 3*CW +: CW] = p1 <<< 1;
			job_data[k*4*CW + 2*CW +: CW] = p2 - p0;
			job_data[k*4*CW + CW +: CW]   = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
			job_data[k*4*CW +: CW]        = (p1 <<< 1) + p1 - (p2 <<< 1) - p2 + p3 - p0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
		end else if (accept) begin
			if (held_eff != 2'd3) begin
				held_q <= held_eff + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (held_eff != 2'd3) begin
				hist_q[held_eff] <= np;
			end else begin
				hist_q[0] <= hist_q[1];
				hist_q[1] <= hist_q[2];
				hist_q[2] <= np;
			end
		end
	end
endmodule

// ===== hdl/crs_queue.sv =====
// two-entry job queue between front and back
// depends on crs_pkg
module crs_queue import crs_pkg::*; #(
	parameter int DATA_W = 12*(COORD_WIDTH_DEF+COEF_GROWTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output logic [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem_q [2];
	logic              wptr_q, rptr_q;
	logic [1:0]        cnt_q;
	logic              push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop)  rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_data;
		end
	end
endmodule

// ===== hdl/crs_back.sv =====
// back end: step generator, reciprocal divider and evaluation pipeline
// depends on crs_pkg
module crs_back import crs_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS  = T_FRAC_BITS_DEF,
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  logic [12*(COORD_WIDTH+COEF_GROWTH)-1:0] job_data,
	input  logic [SEG_CNT_W-1:0]          seg_count,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic signed [COORD_WIDTH-1:0] out_z,
	output logic                          last_of_segment
);
	localparam int W  = COORD_WIDTH;
	localparam int T  = T_FRAC_BITS;
	localparam int CW = COORD_WIDTH + COEF_GROWTH;
	localparam int TW = T_FRAC_BITS + 1;
	localparam int PW = CW + TW + 1;
	localparam int SW = CW + TW + 3;
	localparam int RW = SW - T - 1;
	localparam int STW = $clog2(TW + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_GEN  = 2'd2;

	logic [1:0]           state_q;
	logic [12*CW-1:0]     coef_q;
	logic [SEG_CNT_W-1:0] segs;
	logic [SEG_CNT_W-1:0] rem_q, acc_q, j_q;
	logic [TW-1:0]        quo_q, t_q;
	logic [STW-1:0]       step_q;
	logic [SEG_CNT_W:0]   shifted, acc_sum;
	logic                 adv, drained, issue;

	logic                 v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic                 last_s1, last_s2, last_s3, last_s4;
	logic [TW-1:0]        t_s1, t_s2, t2_s2, t3_s3;
	logic [2*TW-1:0]      tt_prod, t3_prod;
	logic signed [PW-1:0] bt_s3 [3];
	logic signed [PW-1:0] ct2_s3 [3];
	logic signed [PW-1:0] dt3_s4 [3];
	logic signed [SW-1:0] part_s4 [3];
	logic signed [W-1:0]  res [3];

	// effective segment count, clamped to 1..MAX_SEGMENTS
	always_comb begin
		if (seg_count == '0) segs = SEG_CNT_W'(1);
		else if (seg_count > SEG_CNT_W'(MAX_SEGMENTS)) segs = SEG_CNT_W'(MAX_SEGMENTS);
		else segs = seg_count;
	end

	assign adv       = !out_valid_q || out_ready;
	assign drained   = !(v_s1 || v_s2 || v_s3 || v_s4);
	assign job_ready = (state_q == ST_IDLE) && drained;
	assign issue     = (state_q == ST_GEN) && adv;
	assign shifted   = {rem_q, (step_q == '0)};
	assign acc_sum   = {1'b0, acc_q} + {1'b0, rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			acc_q   <= '0;
			j_q     <= '0;
			t_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid && drained) begin
						state_q <= ST_DIV;
						step_q  <= '0;
						rem_q   <= '0;
						quo_q   <= '0;
					end
				end
				ST_DIV: begin
					// restoring divide of one by segs, one quotient bit a cycle
					if (shifted >= {1'b0, segs}) begin
						rem_q <= SEG_CNT_W'(shifted - {1'b0, segs});
						quo_q <= {quo_q[TW-2:0], 1'b1};
					end else begin
						rem_q <= shifted[SEG_CNT_W-1:0];
						quo_q <= {quo_q[TW-2:0], 1'b0};
					end
					step_q <= step_q + STW'(1);
					if (step_q == STW'(T)) begin
						state_q <= ST_GEN;
						t_q     <= '0;
						acc_q   <= '0;
						j_q     <= '0;
					end
				end
				ST_GEN: begin
					if (adv) begin
						if (j_q == segs) begin
							state_q <= ST_IDLE;
						end else begin
							j_q <= j_q + SEG_CNT_W'(1);
							if (acc_sum >= {1'b0, segs}) begin
								acc_q <= SEG_CNT_W'(acc_sum - {1'b0, segs});
								t_q   <= t_q + quo_q + TW'(1);
							end else begin
								acc_q <= acc_sum[SEG_CNT_W-1:0];
								t_q   <= t_q + quo_q;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_ready && job_valid) begin
			coef_q <= job_data;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= issue;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign tt_prod = t_s1 * t_s1;
	assign t3_prod = t2_s2 * t_s2;

	always_comb begin
		logic signed [RW-1:0] r;
		logic signed [SW-1:0] s;
		for (int k = 0; k < 3; k++) begin
			s = part_s4[k] + SW'(dt3_s4[k]) + (SW'(1) <<< T);
			r = RW'(s >>> (T + 1));
			if ((&r[RW-1:W-1]) || !(|r[RW-1:W-1])) res[k] = r[W-1:0];
			else if (r[RW-1]) res[k] = {1'b1, {(W-1){1'b0}}};
			else res[k] = {1'b0, {(W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_q;
			last_s1 <= (j_q == segs);
			t_s2    <= t_s1;
			t2_s2   <= tt_prod[T +: TW];
			last_s2 <= last_s1;
			t3_s3   <= t3_prod[T +: TW];
			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int k = 0; k < 3; k++) begin
				bt_s3[k]   <= $signed(coef_q[k*4*CW + 2*CW +: CW]) * $signed({1'b0, t_s2});
				ct2_s3[k]  <= $signed(coef_q[k*4*CW + CW +: CW]) * $signed({1'b0, t2_s2});
				dt3_s4[k]  <= $signed(coef_q[k*4*CW +: CW]) * $signed({1'b0, t3_s3});
				part_s4[k] <= (SW'($signed(coef_q[k*4*CW + 3*CW +: CW])) <<< T)
					+ SW'(bt_s3[k]) + SW'(ct2_s3[k]);
			end
			out_x           <= res[2];
			out_y           <= res[1];
			out_z           <= res[0];
			last_of_segment <= last_s4;
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ===== tb/tb.sv =====
// self-checking testbench for catmull_rom_spline_evaluator_core
// depends on crs_pkg and the core rtl; predicts every curve point on its own

module tb;
	import crs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int TF = T_FRAC_BITS_DEF;
	localparam int DRAIN_CYCLES = 120;   // longer than one job at the largest count
	localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
		logic                 last;
	} curve_point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SEG_CNT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic new_curve = 1'b0;
	logic signed [CW-1:0] x_coord = '0;
	logic signed [CW-1:0] y_coord = '0;
	logic signed [CW-1:0] z_coord = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;
	logic last_of_segment;

	// predictor state: held control points, their count, the segment count
	longint held_pts [3][3];
	int unsigned pts_held = 0;
	logic [SEG_CNT_W-1:0] seg_reg = SEG_CNT_RESET;

	curve_point_t pending_points [$];
	int mismatches = 0;
	int points_sent = 0;
	int curve_points_seen = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_cycles = 0;

	catmull_rom_spline_evaluator_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .new_curve(new_curve),
		.x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.last_of_segment(last_of_segment)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// one coordinate of the segment at parameter t, rounded and saturated
	function automatic logic signed [CW-1:0] spline_coord(input longint p0, p1, p2, p3,
			input longint t, t2, t3);
		longint a, b, c, d, s, r;
		longint hi, lo;
		a = 2 * p1;
		b = p2 - p0;
		c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
		d = -p0 + 3 * p1 - 3 * p2 + p3;
		s = (a <<< TF) + b * t + c * t2 + d * t3;
		r = (s + (longint'(1) <<< TF)) >>> (TF + 1);
		hi = (longint'(1) <<< (CW - 1)) - 1;
		lo = -hi - 1;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r[CW-1:0];
	endfunction

	// take one accepted control point, queue the curve points it causes
	task automatic predict_segment(input logic nc, input logic signed [CW-1:0] px, py, pz);
		longint np [3];
		longint t, t2, t3;
		int unsigned segs;
		curve_point_t cp;
		logic signed [CW-1:0] v [3];
		np[0] = px;
		np[1] = py;
		np[2] = pz;
		if (nc) pts_held = 0;
		if (pts_held < 3) begin
			for (int k = 0; k < 3; k++) held_pts[pts_held][k] = np[k];
			pts_held++;
			return;
		end
		segs = seg_reg;
		if (segs < 1) segs = 1;
		if (segs > MAX_SEGMENTS_DEF) segs = MAX_SEGMENTS_DEF;
		for (int j = 0; j <= segs; j++) begin
			t = (longint'(j) <<< TF) / segs;
			t2 = (t * t) >>> TF;
			t3 = (t2 * t) >>> TF;
			for (int k = 0; k < 3; k++)
				v[k] = spline_coord(held_pts[0][k], held_pts[1][k], held_pts[2][k], np[k],
						t, t2, t3);
			cp.x = v[0];
			cp.y = v[1];
			cp.z = v[2];
			cp.last = (j == segs);
			pending_points = {pending_points, cp};
		end
		for (int k = 0; k < 3; k++) begin
			held_pts[0][k] = held_pts[1][k];
			held_pts[1][k] = held_pts[2][k];
			held_pts[2][k] = np[k];
		end
	endtask

	// receiver: checks each accepted curve point, then decides on stalling
	always @(posedge clk) begin
		curve_point_t exp_pt;
		if (arst_n && out_valid && out_ready) begin
			curve_points_seen++;
			if (pending_points.size() == 0) begin
				report_mismatch("curve point with none expected");
			end else begin
				exp_pt = pending_points.pop_front();
				if (out_x !== exp_pt.x)
					report_mismatch($sformatf("out_x %0d expected %0d", out_x, exp_pt.x));
				if (out_y !== exp_pt.y)
					report_mismatch($sformatf("out_y %0d expected %0d", out_y, exp_pt.y));
				if (out_z !== exp_pt.z)
					report_mismatch($sformatf("out_z %0d expected %0d", out_z, exp_pt.z));
				if (last_of_segment !== exp_pt.last)
					report_mismatch($sformatf("last_of_segment %0b expected %0b",
							last_of_segment, exp_pt.last));
			end
		end
		if (hold_off_cycles > 0) begin
			hold_off_cycles--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// sends one control point request and waits for it to be taken
	task automatic send_point(input logic nc, input logic signed [CW-1:0] px, py, pz);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		new_curve <= nc;
		x_coord <= px;
		y_coord <= py;
		z_coord <= pz;
		do @(posedge clk); while (!in_ready);
		points_sent++;
		predict_segment(nc, px, py, pz);
	endtask

	// stop sending and wait until every expected curve point has come
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// segment count changes only with the block idle
	task automatic write_segments(input logic [SEG_CNT_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_reg = value;
	endtask

	function automatic logic signed [CW-1:0] random_coord();
		case ($urandom_range(4))
			0: return CW'($urandom());
			1: return CW'($signed(CW'($urandom_range(2000))) - 1000);
			2: return $urandom_range(1) ? C_MAX : C_MIN;
			3: return CW'($signed(CW'($urandom_range(65535))) - 32768);
			default: return CW'($urandom() >>> 3);
		endcase
	endfunction

	task automatic send_random(input int count, input int restart_pct);
		for (int i = 0; i < count; i++)
			send_point($urandom_range(99) < restart_pct, random_coord(), random_coord(),
					random_coord());
	endtask

	// extremes, restarts, a zero count clamped to one and the largest count
	task automatic test_directed();
		write_segments(6'd1);
		send_point(1'b0, '0, '0, '0);
		send_point(1'b0, C_MAX, C_MIN, C_MAX);
		send_point(1'b0, C_MIN, C_MAX, C_MIN);
		send_point(1'b0, C_MAX, C_MIN, C_MAX);
		send_point(1'b0, C_MIN, C_MAX, 24'sd1);
		send_point(1'b1, 24'sd256, -24'sd256, 24'sd0);   // restart drops history
		send_point(1'b0, 24'sd512, 24'sd768, -24'sd1);
		send_point(1'b0, -24'sd1, 24'sd1, 24'sd3);
		send_point(1'b0, 24'sd1000, 24'sd0, -24'sd1000);
		write_segments(6'd0);   // treated as one
		send_point(1'b0, 24'sd5, 24'sd7, 24'sd9);
		send_point(1'b0, -24'sd5, C_MAX, C_MIN);
		write_segments(6'd63);
		send_point(1'b0, 24'sd100, 24'sd200, 24'sd300);
		send_point(1'b0, C_MIN, C_MIN, C_MIN);
		send_point(1'b1, 24'sd1, 24'sd2, 24'sd3);
		send_point(1'b0, 24'sd4, 24'sd5, 24'sd6);
		send_point(1'b0, 24'sd7, 24'sd8, 24'sd9);
		send_point(1'b0, C_MAX, C_MAX, C_MAX);
	endtask

	// random phases under every idling mix
	task automatic test_random_phases();
		int send_mix [4] = '{0, 85, 0, 13};
		int recv_mix [4] = '{0, 0, 85, 13};
		for (int ph = 0; ph < 4; ph++) begin
			write_segments($urandom_range(1) ? 6'(1 + $urandom_range(7)) : 6'd16);
			sender_idle_pct = send_mix[ph];
			receiver_stall_pct = recv_mix[ph];
			send_random(45, 5);
		end
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
	endtask

	// receiver holds off long enough that the job queue fills and input stalls
	task automatic test_backpressure();
		write_segments(6'd4);
		hold_off_cycles = 400;
		send_random(12, 0);
	endtask

	// sender waits for the block to empty, then resumes the same curve
	task automatic test_pause_and_resume();
		write_segments(6'd2);
		receiver_stall_pct = 30;
		send_random(6, 0);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_points.size() != 0);
		send_random(6, 0);
		receiver_stall_pct = 0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_phases();
		test_backpressure();
		test_pause_and_resume();
		drain();
		$display("sent %0d control points, checked %0d curve points over counts 0..63",
				points_sent, curve_points_seen);
		$display("with input gaps, output stalls, a long hold-off and restarts");
		if (mismatches == 0 && pending_points.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
